[sv/fbfla_pkg.sv]
`timescale 1ns / 1ps

package fbfla_pkg;

    // Fixed field widths of the request and result transactions
    localparam int IDX_FIELD_W = 6;
    localparam int CNT_FIELD_W = 7;
    localparam int STATUS_W    = 2;

    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    typedef enum logic {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_ALLOC = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

endpackage

[sv/fbfla_ram.sv]
`timescale 1ns / 1ps

module fbfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[sv/fixed_block_free_list_allocator.sv]
`timescale 1ns / 1ps
// Alloc and free requests in any mix pass the input register and then the result register.
// Throughput: one request per cycle unless the result stream stalls; the link of the list head
// is forwarded from the previous pop's registered link memory read, so pops chain back to back.
// Reset (rst_n low, asynchronous): empty pipeline, block_count = min(64, NUM_BLOCKS),
// free list empty, no block issued, all in-use marks clear. A block_count write does the same
// to the pool; the link memory is never cleared.

module fixed_block_free_list_allocator #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration
    input  logic                            block_count_we,
    input  logic [fbfla_pkg::CNT_FIELD_W-1:0] block_count_wdata,
    // request stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [fbfla_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [5:0] block_index, [7:6] zero
    input  logic                            s_axis_tuser,   // [0] req_type
    // result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [fbfla_pkg::M_TDATA_W-1:0] m_axis_tdata    // [1:0] status, [7:2] granted_index
);

    localparam int IDX_W  = (NUM_BLOCKS > 2) ? $clog2(NUM_BLOCKS) : 1;
    localparam int LINK_W = $clog2(NUM_BLOCKS + 1);
    localparam int CMP_W  = (LINK_W > fbfla_pkg::CNT_FIELD_W) ? LINK_W : fbfla_pkg::CNT_FIELD_W;
    localparam logic [LINK_W-1:0] NULL_LINK   = LINK_W'(NUM_BLOCKS);
    localparam logic [LINK_W-1:0] RESET_COUNT = LINK_W'((NUM_BLOCKS < 64) ? NUM_BLOCKS : 64);

    // input register
    logic                                in_vld_reg;
    fbfla_pkg::req_t                     in_req_reg;
    logic [fbfla_pkg::IDX_FIELD_W-1:0]   in_idx_reg;

    // result register
    logic                                out_vld_reg;
    fbfla_pkg::status_t                  out_status_reg;
    logic [fbfla_pkg::IDX_FIELD_W-1:0]   out_grant_reg;

    // pool state
    logic [LINK_W-1:0]     block_count_reg;
    logic [LINK_W-1:0]     free_head_reg, free_head_next;
    logic [LINK_W-1:0]     head_link_reg, head_link_next;
    logic                  link_in_ram_reg, link_in_ram_next;
    logic [LINK_W-1:0]     fresh_count_reg, fresh_count_next;
    logic [NUM_BLOCKS-1:0] in_use_reg, in_use_next;

    // link memory port
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [LINK_W-1:0] ram_rdata;

    logic                              out_free;
    logic                              fire;
    logic [LINK_W-1:0]                 head_link;
    logic [LINK_W-1:0]                 pop_head;
    logic                              head_valid;
    logic [CMP_W-1:0]                  idx_ext;
    logic [IDX_W-1:0]                  idx_blk;
    logic [CMP_W-1:0]                  wdata_ext;
    logic [LINK_W-1:0]                 count_sat;
    logic [IDX_W-1:0]                  grant;
    fbfla_pkg::status_t                status;
    logic [fbfla_pkg::IDX_FIELD_W-1:0] grant_field;

    fbfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (NUM_BLOCKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free      = !out_vld_reg || m_axis_tready;
    assign fire          = in_vld_reg && out_free;
    assign s_axis_tready = !in_vld_reg || out_free;

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {out_grant_reg, out_status_reg};

    // link of the current head: held register after a push, memory output after a pop
    assign head_link  = link_in_ram_reg ? ram_rdata : head_link_reg;
    assign pop_head   = (head_link < NULL_LINK) ? head_link : NULL_LINK;
    assign head_valid = free_head_reg < NULL_LINK;

    assign idx_ext = CMP_W'(in_idx_reg);
    assign idx_blk = idx_ext[IDX_W-1:0];

    assign wdata_ext = CMP_W'(block_count_wdata);
    assign count_sat = (wdata_ext > CMP_W'(NUM_BLOCKS)) ? NULL_LINK : wdata_ext[LINK_W-1:0];

    always_comb
    begin
        free_head_next   = free_head_reg;
        head_link_next   = head_link_reg;
        link_in_ram_next = link_in_ram_reg;
        fresh_count_next = fresh_count_reg;
        in_use_next      = in_use_reg;
        ram_we           = 1'b0;
        ram_waddr        = idx_blk;
        ram_wdata        = free_head_reg;
        ram_re           = 1'b0;
        ram_raddr        = pop_head[IDX_W-1:0];
        grant            = '0;
        status           = fbfla_pkg::ST_OK;

        if (in_req_reg == fbfla_pkg::REQ_ALLOC)
        begin
            if (head_valid)
            begin
                // pop; fetch the new head's link for the next pop
                grant            = free_head_reg[IDX_W-1:0];
                free_head_next   = pop_head;
                ram_re           = fire && (pop_head < NULL_LINK);
                link_in_ram_next = 1'b1;
                in_use_next[grant] = 1'b1;
            end
            else if (fresh_count_reg < block_count_reg)
            begin
                grant              = fresh_count_reg[IDX_W-1:0];
                fresh_count_next   = fresh_count_reg + LINK_W'(1);
                in_use_next[grant] = 1'b1;
            end
            else
            begin
                status = fbfla_pkg::ST_EMPTY;
            end
        end
        else
        begin
            if (idx_ext >= CMP_W'(block_count_reg))
            begin
                status = fbfla_pkg::ST_RANGE;
            end
            else if (!in_use_reg[idx_blk])
            begin
                status = fbfla_pkg::ST_NOT_ALLOC;
            end
            else
            begin
                // push; the old head becomes this block's link
                in_use_next[idx_blk] = 1'b0;
                ram_we               = fire;
                free_head_next       = LINK_W'(idx_blk);
                head_link_next       = free_head_reg;
                link_in_ram_next     = 1'b0;
            end
        end
    end

    always_comb
    begin
        logic [CMP_W-1:0] grant_ext;
        grant_ext = CMP_W'(grant);
        if (status == fbfla_pkg::ST_OK && in_req_reg == fbfla_pkg::REQ_ALLOC)
        begin
            grant_field = grant_ext[fbfla_pkg::IDX_FIELD_W-1:0];
        end
        else
        begin
            grant_field = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            block_count_reg <= RESET_COUNT;
            free_head_reg   <= NULL_LINK;
            link_in_ram_reg <= 1'b0;
            fresh_count_reg <= '0;
            in_use_reg      <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_vld_reg <= s_axis_tvalid;
            end
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end

            if (block_count_we)
            begin
                // clear the pool
                block_count_reg <= count_sat;
                free_head_reg   <= NULL_LINK;
                link_in_ram_reg <= 1'b0;
                fresh_count_reg <= '0;
                in_use_reg      <= '0;
            end
            else if (fire)
            begin
                free_head_reg   <= free_head_next;
                link_in_ram_reg <= link_in_ram_next;
                fresh_count_reg <= fresh_count_next;
                in_use_reg      <= in_use_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_req_reg <= fbfla_pkg::req_t'(s_axis_tuser);
            in_idx_reg <= s_axis_tdata[fbfla_pkg::IDX_FIELD_W-1:0];
        end
        if (fire)
        begin
            out_status_reg <= status;
            out_grant_reg  <= grant_field;
            head_link_reg  <= head_link_next;
        end
    end

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fresh_count_reg <= block_count_reg)
        else $error("fresh count passed block count");

    a_head_not_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        (free_head_reg < NULL_LINK) |-> !in_use_reg[free_head_reg[IDX_W-1:0]])
        else $error("free list head is marked in use");

    a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !block_count_we && in_req_reg == fbfla_pkg::REQ_ALLOC
            && status == fbfla_pkg::ST_OK)
        |=> in_use_reg[$past(grant)])
        else $error("granted block not marked in use");

    a_pop_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !block_count_we && in_req_reg == fbfla_pkg::REQ_ALLOC && head_valid)
        |=> (free_head_reg == $past(pop_head)))
        else $error("pop did not advance head to forwarded link");

endmodule
